### rtl/cfsm_pkg.sv
// Shared constants, codes and word types for the circular frame scroll mapper.
package cfsm_pkg;

  // Frame memory geometry
  localparam int VISIBLE_LINES = 240;
  localparam int TOTAL_LINES   = 320;
  localparam int ROW_W         = $clog2(TOTAL_LINES);
  localparam int VIS_MOD       = VISIBLE_LINES % TOTAL_LINES;

  // Internal arithmetic width, holds every sum before its reduction modulo the total
  localparam int ACC_W = 11;
  // Conditional subtracts needed to reduce an ACC_W value modulo the total
  localparam int MOD_K = $clog2((2 ** ACC_W) / TOTAL_LINES);

  // Result words per item
  localparam int MAX_RES = 3;
  localparam int CNT_W   = 2;

  // Opcodes
  localparam logic OP_DIR   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Requested directions
  localparam logic [2:0] DIR_NONE       = 3'd0;
  localparam logic [2:0] DIR_UP         = 3'd1;
  localparam logic [2:0] DIR_DOWN       = 3'd2;
  localparam logic [2:0] DIR_LEFT       = 3'd3;
  localparam logic [2:0] DIR_RIGHT      = 3'd4;
  localparam logic [2:0] DIR_LEFT_ANIM  = 3'd5;
  localparam logic [2:0] DIR_RIGHT_ANIM = 3'd6;
  localparam logic [2:0] DIR_INVALID    = 3'd7;

  // Renderer direction codes
  localparam logic [2:0] RD_NORMAL     = 3'd0;
  localparam logic [2:0] RD_DOWN       = 3'd1;
  localparam logic [2:0] RD_RIGHT      = 3'd2;
  localparam logic [2:0] RD_LEFT       = 3'd3;
  localparam logic [2:0] RD_LEFT_ANIM  = 3'd4;
  localparam logic [2:0] RD_RIGHT_ANIM = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_SCROLL = 2'd0;
  localparam logic [1:0] KIND_WINDOW = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  typedef struct packed {
    logic       opcode;
    logic [2:0] direction;
    logic [7:0] col_first;
    logic [7:0] col_final;
    logic [7:0] row_first;
    logic [7:0] row_final;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  draw_col;
    logic [8:0]  draw_row;
    logic [7:0]  draw_width;
    logic [8:0]  draw_height;
    logic [15:0] pixel_offset;
    logic [8:0]  scroll_address;
    logic [2:0]  render_direction;
    logic        last;
  } result_t;

  typedef result_t [MAX_RES-1:0] result_set_t;

endpackage

### rtl/cfsm_core.sv
// Scroll state registers and the single-pass mapping of one item to its result words.
module cfsm_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  cfsm_pkg::item_t              item,
  output cfsm_pkg::result_set_t        res,
  output logic [cfsm_pkg::CNT_W-1:0]   res_cnt
);
  import cfsm_pkg::*;

  localparam logic [ACC_W-1:0] T_A    = ACC_W'(TOTAL_LINES);
  localparam logic [ACC_W-1:0] VM_A   = ACC_W'(VIS_MOD);
  localparam logic [ACC_W-1:0] VEND_A = ACC_W'(VISIBLE_LINES - 1);

  // value below twice the total
  function automatic logic [ACC_W-1:0] red1(input logic [ACC_W-1:0] x);
    return (x >= T_A) ? (x - T_A) : x;
  endfunction

  // any ACC_W value, binary descent over multiples of the total
  function automatic logic [ACC_W-1:0] mod_t(input logic [ACC_W-1:0] x);
    logic [ACC_W-1:0] v;
    v = x;
    for (int k = MOD_K - 1; k >= 0; k--) begin
      if (v >= (T_A << k)) v = v - (T_A << k);
    end
    return v;
  endfunction

  logic [2:0]       mode_r, mode_nxt;
  logic [ROW_W-1:0] wofs_r, wofs_nxt;
  logic [ROW_W-1:0] sstart_r, sstart_nxt;
  logic [2:0]       rdir_r, rdir_nxt;

  logic [ACC_W-1:0] ya_a, yb_a, x1_a, x2_a, wofs_a, ss_a;
  logic [ACC_W-1:0] wo_eff, r1, r2, h1, step_a, smod, ss_dn, ss_up;
  logic [7:0]       width;
  logic [8:0]       height;
  logic [16:0]      pix_full;
  logic             dn_mode, up_mode, dn_go, up_go, sc_go, sc_end, lr_end, wrap;
  logic [2:0]       rdir_arm;
  result_t          rep, sc, w1, w2;

  always_comb begin
    ya_a   = ACC_W'(item.row_first);
    yb_a   = ACC_W'(item.row_final);
    x1_a   = ACC_W'(item.col_first);
    x2_a   = ACC_W'(item.col_final);
    wofs_a = ACC_W'(wofs_r);
    ss_a   = ACC_W'(sstart_r);

    dn_mode = (mode_r == DIR_DOWN);
    up_mode = (mode_r == DIR_UP);

    // write offset moves at the opening edge of a vertical scroll
    if (dn_mode && yb_a == VEND_A) begin
      wo_eff = red1(wofs_a + T_A - VM_A);
    end else if (up_mode && ya_a == '0) begin
      wo_eff = red1(wofs_a + VM_A);
    end else begin
      wo_eff = wofs_a;
    end

    r1     = mod_t(ya_a + wo_eff);
    r2     = mod_t(yb_a + wo_eff);
    width  = item.col_final - item.col_first + 8'd1;
    height = 9'(item.row_final) - 9'(item.row_first) + 9'd1;

    dn_go  = dn_mode && (yb_a < VEND_A);
    up_go  = up_mode && (ya_a != '0);
    sc_go  = dn_go || up_go;
    sc_end = (dn_go && ya_a == '0) || (up_go && yb_a == VEND_A);
    lr_end = ((mode_r == DIR_LEFT || mode_r == DIR_LEFT_ANIM) && x2_a == VEND_A) ||
             ((mode_r == DIR_RIGHT || mode_r == DIR_RIGHT_ANIM) && x1_a == '0);

    step_a = sc_end ? ACC_W'({height, 1'b0}) : ACC_W'(height);
    smod   = mod_t(step_a);
    ss_dn  = red1(ss_a + T_A - smod);
    ss_up  = red1(ss_a + smod);

    wrap     = (r2 < r1);
    h1       = T_A - r1;
    pix_full = 17'(width) * 17'(h1);

    // renderer code for a newly armed direction; up keeps the current code
    unique case (item.direction)
      DIR_DOWN:       rdir_arm = RD_DOWN;
      DIR_RIGHT:      rdir_arm = RD_RIGHT;
      DIR_LEFT:       rdir_arm = RD_LEFT;
      DIR_RIGHT_ANIM: rdir_arm = RD_RIGHT_ANIM;
      DIR_LEFT_ANIM:  rdir_arm = RD_LEFT_ANIM;
      default:        rdir_arm = rdir_r;
    endcase

    mode_nxt   = mode_r;
    wofs_nxt   = wofs_r;
    sstart_nxt = sstart_r;
    rdir_nxt   = rdir_r;
    if (item.opcode == OP_DIR) begin
      if (mode_r == DIR_NONE && item.direction != DIR_INVALID) begin
        mode_nxt = item.direction;
        rdir_nxt = rdir_arm;
      end
    end else begin
      wofs_nxt = ROW_W'(wo_eff);
      if (dn_go) sstart_nxt = ROW_W'(ss_dn);
      if (up_go) sstart_nxt = ROW_W'(ss_up);
      if (sc_end || lr_end) begin
        mode_nxt = DIR_NONE;
        rdir_nxt = RD_NORMAL;
      end
    end

    rep                  = '0;
    rep.kind             = KIND_REPORT;
    rep.render_direction = rdir_nxt;
    rep.last             = 1'b1;

    sc                = '0;
    sc.kind           = KIND_SCROLL;
    sc.scroll_address = 9'(sstart_nxt);

    w1             = '0;
    w1.kind        = KIND_WINDOW;
    w1.draw_col    = item.col_first;
    w1.draw_row    = 9'(r1);
    w1.draw_width  = width;
    w1.draw_height = wrap ? 9'(h1) : height;

    w2              = '0;
    w2.kind         = KIND_WINDOW;
    w2.draw_col     = item.col_first;
    w2.draw_width   = width;
    w2.draw_height  = 9'(r2 + ACC_W'(1));
    w2.pixel_offset = pix_full[15:0];
    w2.last         = 1'b1;

    w1.last = !wrap;

    res = '0;
    if (item.opcode == OP_DIR) begin
      res[0]  = rep;
      res_cnt = CNT_W'(1);
    end else if (sc_go) begin
      res[0] = sc;
      res[1] = w1;
      if (wrap) res[2] = w2;
      res_cnt = wrap ? CNT_W'(3) : CNT_W'(2);
    end else begin
      res[0] = w1;
      if (wrap) res[1] = w2;
      res_cnt = wrap ? CNT_W'(2) : CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= DIR_NONE;
      wofs_r   <= '0;
      sstart_r <= '0;
      rdir_r   <= RD_NORMAL;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      wofs_r   <= wofs_nxt;
      sstart_r <= sstart_nxt;
      rdir_r   <= rdir_nxt;
    end
  end

endmodule

### rtl/cfsm_outbuf.sv
// Result bank: holds one item's result words, gives one per cycle while out_ready is 1.
module cfsm_outbuf (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  cfsm_pkg::result_set_t        load_res,
  input  logic [cfsm_pkg::CNT_W-1:0]   load_cnt,
  output logic                         free,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cfsm_pkg::result_t            out_res
);
  import cfsm_pkg::*;

  result_set_t      ent_r, ent_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             take;

  always_comb begin
    case (idx_r)
      CNT_W'(1): out_res = ent_r[1];
      CNT_W'(2): out_res = ent_r[2];
      default:   out_res = ent_r[0];
    endcase

    out_valid = (cnt_r != '0);
    take      = out_valid && out_ready;
    // empty, or the final word leaves this cycle
    free      = !out_valid || (take && out_res.last);

    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      ent_nxt = load_res;
      cnt_nxt = load_cnt;
      idx_nxt = '0;
    end else if (take) begin
      if (out_res.last) begin
        cnt_nxt = '0;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

### rtl/circular_frame_scroll_mapper.sv
// Top level of the circular frame scroll mapper: input register, mapping core, result bank.
//
//  channel  dir  handshake              word
//  in_      in   in_valid / in_ready    opcode, direction, area columns and rows
//  out_     out  out_valid / out_ready  kind, draw window, pixel offset, scroll addr,
//                                       renderer code, last
//
// An accepted word is registered in the input register, moves into the result bank
// once the bank is free, and is mapped in one pass against the scroll state on the
// way. The bank gives one result word per cycle while out_ready is high, so an item
// yields one word (direction, plain flush) up to three words (scroll address plus a
// wrapped window pair). rst_n (synchronous) clears scroll mode, write offset, scroll
// start and renderer code. The input register takes a new word while the bank still
// waits on out_ready only if the input register is empty.
module circular_frame_scroll_mapper (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [2:0]  in_direction,
  input  logic [7:0]  in_col_first,
  input  logic [7:0]  in_col_final,
  input  logic [7:0]  in_row_first,
  input  logic [7:0]  in_row_final,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_draw_col,
  output logic [8:0]  out_draw_row,
  output logic [7:0]  out_draw_width,
  output logic [8:0]  out_draw_height,
  output logic [15:0] out_pixel_offset,
  output logic [8:0]  out_scroll_address,
  output logic [2:0]  out_render_direction,
  output logic        out_last
);
  import cfsm_pkg::*;

  // input register
  logic             in_v_r, in_v_nxt;
  item_t            item_r, item_nxt;

  logic             buf_free;
  logic             load;
  result_set_t      core_res;
  logic [CNT_W-1:0] core_cnt;
  result_t          out_res;

  // the held word moves into the bank as soon as the bank frees up
  assign load     = in_v_r && buf_free;
  assign in_ready = !in_v_r || buf_free;

  always_comb begin
    item_nxt = item_r;
    in_v_nxt = in_v_r;
    if (in_valid && in_ready) begin
      item_nxt.opcode    = in_opcode;
      item_nxt.direction = in_direction;
      item_nxt.col_first = in_col_first;
      item_nxt.col_final = in_col_final;
      item_nxt.row_first = in_row_first;
      item_nxt.row_final = in_row_final;
      in_v_nxt           = 1'b1;
    end else if (load) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  cfsm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (load),
    .item    (item_r),
    .res     (core_res),
    .res_cnt (core_cnt)
  );

  cfsm_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_res  (core_res),
    .load_cnt  (core_cnt),
    .free      (buf_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind             = out_res.kind;
  assign out_draw_col         = out_res.draw_col;
  assign out_draw_row         = out_res.draw_row;
  assign out_draw_width       = out_res.draw_width;
  assign out_draw_height      = out_res.draw_height;
  assign out_pixel_offset     = out_res.pixel_offset;
  assign out_scroll_address   = out_res.scroll_address;
  assign out_render_direction = out_res.render_direction;
  assign out_last             = out_res.last;

endmodule
